FILE: design/ezt_pkg.sv
// Package: shared types, constants and the CORDIC arctangent table.
`timescale 1ns / 1ps
`default_nettype none
package ezt_pkg;
  localparam int IFRAC = 30;
  localparam int DW = 34;
  localparam logic signed [DW-1:0] GAIN_INIT = 34'sd652032874;

  typedef logic signed [DW-1:0] cval_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    logic signed [32:0] z;
  } cord_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051E;
      5'd2: v = 32'h09FB385B;  5'd3: v = 32'h051111D4;
      5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;
      5'd8: v = 32'h0028BE53;  5'd9: v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001; default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Q3.30 product floored back to Q3.30
  function automatic cval_t mulq(input cval_t a, input cval_t b);
    logic signed [2*DW-1:0] p;
    p = a * b;
    return cval_t'(p >>> IFRAC);
  endfunction
endpackage
`default_nettype wire

FILE: design/euler_zxy_to_transform_core.sv
// Top level: pose to 3x4 rigid transform, Euler order Z-X-Y.
`timescale 1ns / 1ps
`default_nettype none
// One pose enters and one transform leaves per cycle while the output is not
// stalled. The pipeline is one angle-folding stage, a chain of CORDIC_STAGES
// rotation cells (all three angles in parallel), two product stages, one
// sum stage and one round/saturate output register. The whole pipeline
// advances when the output register is empty or being taken, so a stall
// holds every stage in place. Entries are Q1.(COEF_FRAC_BITS) saturated to
// +-1.0; translations pass through unchanged.
module euler_zxy_to_transform_core #(
  parameter int ANGLE_BITS = 16,
  parameter int COEF_FRAC_BITS = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], roll[111:96], pitch[127:112],
  // yaw[143:128]
  input  wire logic [143:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // r00,r01,r02,r10,r11,r12,r20,r21,r22 (EW bits each from bit 0), then
  // out_x, out_y, out_z (32 bits each), zero fill to whole bytes
  output logic [((9*(COEF_FRAC_BITS+2) + 96 + 7) / 8) * 8 - 1:0] out_tdata
);
  localparam int EW = COEF_FRAC_BITS + 2;
  localparam int RAW = 9*EW + 96;
  localparam int OW = ((RAW + 7) / 8) * 8;
  localparam int L = CORDIC_STAGES + 4;  // stages before the output register
  localparam int SH = ezt_pkg::IFRAC - COEF_FRAC_BITS;

  logic adv;
  logic [L-1:0] vld_r;
  logic [95:0] pos_r [L];

  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  // angle fold stage
  ezt_pkg::cord_t c0_r [3];
  logic [2:0] flip0_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic [31:0] fld;
        logic [ANGLE_BITS-1:0] a;
        logic signed [32:0] z;
        logic f;
        fld = {16'h0000, in_tdata[96 + 16*k +: 16]};
        a = fld[ANGLE_BITS-1:0];
        z = 33'($signed({a, {(32-ANGLE_BITS){1'b0}}}));
        f = 1'b0;
        if (z > 33'sd1073741824) begin
          z = z - 33'sd2147483648;
          f = 1'b1;
        end else if (z < -33'sd1073741824) begin
          z = z + 33'sd2147483648;
          f = 1'b1;
        end
        flip0_r[k] <= f;
        c0_r[k].x <= ezt_pkg::GAIN_INIT;
        c0_r[k].y <= '0;
        c0_r[k].z <= z;
      end
    end
  end

  ezt_pkg::cord_t chain [CORDIC_STAGES+1][3];
  logic [2:0] flip_r [CORDIC_STAGES+1];
  assign chain[0] = c0_r;
  assign flip_r[0] = flip0_r;
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    logic [2:0] f_r;
    ezt_cell #(.STAGE(g)) u_cell (.clk(clk), .en(adv), .in_c(chain[g]),
      .out_c(chain[g+1]));
    always_ff @(posedge clk) begin
      if (adv) f_r <= flip_r[g];
    end
    assign flip_r[g+1] = f_r;
  end

  // sin/cos after sign fix: index 0 roll, 1 pitch, 2 yaw
  ezt_pkg::cval_t s [3], c [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s[k] = flip_r[CORDIC_STAGES][k] ? -chain[CORDIC_STAGES][k].y
                                      : chain[CORDIC_STAGES][k].y;
      c[k] = flip_r[CORDIC_STAGES][k] ? -chain[CORDIC_STAGES][k].x
                                      : chain[CORDIC_STAGES][k].x;
    end
  end

  // product stage one
  ezt_pkg::cval_t cycp_r, crsy_r, cysp_r, cpsy_r, crcy_r, sysp_r, crsp_r, crcp_r;
  ezt_pkg::cval_t srsy_r, cpsr_r, cysr_r, sr_r, sp_r, sy_r, srb_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      cycp_r <= ezt_pkg::mulq(c[2], c[1]);
      crsy_r <= ezt_pkg::mulq(c[0], s[2]);
      cysp_r <= ezt_pkg::mulq(c[2], s[1]);
      cpsy_r <= ezt_pkg::mulq(c[1], s[2]);
      crcy_r <= ezt_pkg::mulq(c[0], c[2]);
      sysp_r <= ezt_pkg::mulq(s[2], s[1]);
      crsp_r <= ezt_pkg::mulq(c[0], s[1]);
      crcp_r <= ezt_pkg::mulq(c[0], c[1]);
      srsy_r <= ezt_pkg::mulq(s[0], s[2]);
      cpsr_r <= ezt_pkg::mulq(c[1], s[0]);
      cysr_r <= ezt_pkg::mulq(c[2], s[0]);
      sr_r <= s[0];
      sp_r <= s[1];
      sy_r <= s[2];
    end
  end

  // product stage two: triple products
  ezt_pkg::cval_t t0_r, t2_r, t3_r, t5_r;
  ezt_pkg::cval_t p_cycp_r, p_crsy_r, p_cysp_r, p_cpsy_r, p_crcy_r, p_sysp_r;
  ezt_pkg::cval_t p_crsp_r, p_crcp_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      t0_r <= ezt_pkg::mulq(srsy_r, sp_r);
      t2_r <= ezt_pkg::mulq(cpsr_r, sy_r);
      t3_r <= ezt_pkg::mulq(cysr_r, sp_r);
      t5_r <= ezt_pkg::mulq(cycp_r, sr_r);
      p_cycp_r <= cycp_r; p_crsy_r <= crsy_r; p_cysp_r <= cysp_r;
      p_cpsy_r <= cpsy_r; p_crcy_r <= crcy_r; p_sysp_r <= sysp_r;
      p_crsp_r <= crsp_r; p_crcp_r <= crcp_r; srb_r <= sr_r;
    end
  end

  // sum stage
  ezt_pkg::cval_t e_r [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      e_r[0] <= p_cycp_r - t0_r;
      e_r[1] <= -p_crsy_r;
      e_r[2] <= p_cysp_r + t2_r;
      e_r[3] <= p_cpsy_r + t3_r;
      e_r[4] <= p_crcy_r;
      e_r[5] <= p_sysp_r - t5_r;
      e_r[6] <= -p_crsp_r;
      e_r[7] <= srb_r;
      e_r[8] <= p_crcp_r;
    end
  end

  // translations and valid travel alongside
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[L-2:0], in_tvalid};
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r[0] <= in_tdata[95:0];
      for (int k = 1; k < L; k++) pos_r[k] <= pos_r[k-1];
    end
  end

  // round half up and saturate
  function automatic logic [EW-1:0] to_entry(input ezt_pkg::cval_t v);
    logic signed [ezt_pkg::DW:0] w;
    logic signed [ezt_pkg::DW:0] lim;
    w = (ezt_pkg::DW+1)'(v);
    if (SH > 0) w = (w + ((ezt_pkg::DW+1)'(1) <<< (SH > 0 ? SH-1 : 0))) >>> SH;
    lim = (ezt_pkg::DW+1)'(1) <<< COEF_FRAC_BITS;
    if (w > lim) w = lim;
    if (w < -lim) w = -lim;
    return w[EW-1:0];
  endfunction

  logic [OW-1:0] od;
  always_comb begin
    od = '0;
    for (int k = 0; k < 9; k++) od[k*EW +: EW] = to_entry(e_r[k]);
    od[9*EW +: 96] = pos_r[L-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (adv) begin
      out_tvalid <= vld_r[L-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) out_tdata <= od;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("ready does not follow output state");
  a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[L-1] |=> out_tvalid)
    else $error("pipeline item lost");
endmodule
`default_nettype wire

FILE: design/ezt_cell.sv
// One CORDIC rotation cell for three angles, with enable.
`timescale 1ns / 1ps
`default_nettype none
module ezt_cell #(
  parameter int STAGE = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire ezt_pkg::cord_t in_c [3],
  output ezt_pkg::cord_t     out_c [3]
);
  localparam logic [4:0] IDX = 5'(STAGE % 32);
  localparam int SH = STAGE % 32;
  ezt_pkg::cord_t c_r [3];
  logic signed [32:0] at;
  assign at = $signed({1'b0, ezt_pkg::atan_lut(IDX)});

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (!in_c[k].z[32]) begin
          c_r[k].x <= in_c[k].x - (in_c[k].y >>> SH);
          c_r[k].y <= in_c[k].y + (in_c[k].x >>> SH);
          c_r[k].z <= in_c[k].z - at;
        end else begin
          c_r[k].x <= in_c[k].x + (in_c[k].y >>> SH);
          c_r[k].y <= in_c[k].y - (in_c[k].x >>> SH);
          c_r[k].z <= in_c[k].z + at;
        end
      end
    end
  end
  assign out_c = c_r;
endmodule
`default_nettype wire
